// File: src/dpmsc_pkg.sv
// shared types and constants of the dual wheel pi speed controller
`timescale 1ns / 1ps

package dpmsc_pkg;

   localparam int MODE_W     = 3;
   localparam int PHASE_W    = 2;
   localparam int AVG_W      = 8;
   localparam int TARGET_W   = 11;
   localparam int MEAS_W     = 12;
   localparam int DUTY_W     = 16;
   localparam int LIMIT_W    = 16;
   localparam int PGAIN_W    = 12;
   localparam int IGAIN_W    = 2;
   localparam int INTEG_W    = 11;
   localparam int ERR_W      = 13;
   localparam int SUM_W      = 14;
   localparam int PPROD_W    = 25;
   localparam int IPROD_W    = 13;
   localparam int DRIVE_W    = 26;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [MODE_W-1:0] MODE_SEARCH   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_AVOID    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_APPROACH = 3'd2;
   localparam logic [MODE_W-1:0] MODE_NEAR     = 3'd3;

   localparam logic [PHASE_W-1:0] PHASE_ACCEL   = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_REACCEL = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_DECEL   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_FORWARD_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE_LIMIT = 1'd1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd10000;

   localparam logic [PGAIN_W-1:0] PGAIN_RESET = 12'd400;
   localparam logic [PGAIN_W-1:0] PGAIN_BASE  = 12'd800;
   localparam logic [PGAIN_W-1:0] PGAIN_DECEL = 12'd1000;
   localparam logic [PGAIN_W-1:0] PGAIN_FAST  = 12'd2500;

   localparam logic [IGAIN_W-1:0] IGAIN_OFF  = 2'd0;
   localparam logic [IGAIN_W-1:0] IGAIN_ONE  = 2'd1;
   localparam logic [IGAIN_W-1:0] IGAIN_SLOW = 2'd3;

   localparam logic [AVG_W-1:0] SPEED_THRESHOLD = 8'd11;

   localparam logic signed [INTEG_W-1:0] INTEG_PRESET = 11'sd800;
   localparam logic signed [SUM_W-1:0]   INTEG_HIGH   = 14'sd800;
   localparam logic signed [SUM_W-1:0]   INTEG_LOW    = -14'sd400;

   typedef struct packed {
      logic [PGAIN_W-1:0] prop_gain;
      logic [IGAIN_W-1:0] integ_gain;
      logic               preset;
   } gains_type;

   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_s3;
   } pipe_ctrl_type;

endpackage

// File: src/dpmsc_if.sv
// handshake channels of the dual wheel pi speed controller
`timescale 1ns / 1ps

interface dpmsc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [dpmsc_pkg::MODE_W-1:0]          mode;
   logic [dpmsc_pkg::PHASE_W-1:0]         speed_phase;
   logic [dpmsc_pkg::AVG_W-1:0]           average_speed;
   logic [dpmsc_pkg::TARGET_W-1:0]        left_target;
   logic [dpmsc_pkg::TARGET_W-1:0]        right_target;
   logic signed [dpmsc_pkg::MEAS_W-1:0]   left_measured;
   logic signed [dpmsc_pkg::MEAS_W-1:0]   right_measured;

   modport source (output valid, mode, speed_phase, average_speed, left_target,
                   right_target, left_measured, right_measured, input ready);
   modport sink (input valid, mode, speed_phase, average_speed, left_target,
                 right_target, left_measured, right_measured, output ready);
endinterface

interface dpmsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dpmsc_pkg::DUTY_W-1:0]  left_forward_duty;
   logic [dpmsc_pkg::DUTY_W-1:0]  left_reverse_duty;
   logic [dpmsc_pkg::DUTY_W-1:0]  right_forward_duty;
   logic [dpmsc_pkg::DUTY_W-1:0]  right_reverse_duty;

   modport source (output valid, left_forward_duty, left_reverse_duty,
                   right_forward_duty, right_reverse_duty, input ready);
   modport sink (input valid, left_forward_duty, left_reverse_duty,
                 right_forward_duty, right_reverse_duty, output ready);
endinterface

interface dpmsc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [dpmsc_pkg::CSR_IDX_W-1:0]   index;
   logic [dpmsc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: src/dpmsc_sched.sv
// gain scheduler: mode change detection and shared gain registers
`timescale 1ns / 1ps

module dpmsc_sched (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [dpmsc_pkg::MODE_W-1:0]     mode,
   input  logic [dpmsc_pkg::PHASE_W-1:0]    speed_phase,
   input  logic [dpmsc_pkg::AVG_W-1:0]      average_speed,
   output dpmsc_pkg::gains_type             gains
);

   logic [dpmsc_pkg::MODE_W-1:0]  last_mode_ff;
   logic [dpmsc_pkg::PGAIN_W-1:0] prop_gain_ff;
   logic [dpmsc_pkg::PGAIN_W-1:0] prop_gain_in;
   logic [dpmsc_pkg::IGAIN_W-1:0] integ_gain_ff;
   logic [dpmsc_pkg::IGAIN_W-1:0] integ_gain_in;
   logic                          preset;

   always_comb begin
      prop_gain_in  = prop_gain_ff;
      integ_gain_in = integ_gain_ff;
      preset        = 1'b0;
      if (mode != last_mode_ff) begin
         case (mode)
            dpmsc_pkg::MODE_SEARCH: begin
               prop_gain_in  = dpmsc_pkg::PGAIN_BASE;
               integ_gain_in = dpmsc_pkg::IGAIN_OFF;
            end
            dpmsc_pkg::MODE_AVOID: begin
               prop_gain_in = dpmsc_pkg::PGAIN_BASE;
            end
            dpmsc_pkg::MODE_APPROACH: begin
               case (speed_phase)
                  dpmsc_pkg::PHASE_ACCEL: begin
                     prop_gain_in = dpmsc_pkg::PGAIN_BASE;
                  end
                  dpmsc_pkg::PHASE_REACCEL: begin
                     prop_gain_in  = dpmsc_pkg::PGAIN_BASE;
                     integ_gain_in = dpmsc_pkg::IGAIN_ONE;
                     preset        = 1'b1;
                  end
                  dpmsc_pkg::PHASE_DECEL: begin
                     prop_gain_in  = dpmsc_pkg::PGAIN_DECEL;
                     integ_gain_in = dpmsc_pkg::IGAIN_OFF;
                  end
                  default: begin
                  end
               endcase
            end
            dpmsc_pkg::MODE_NEAR: begin
               if (average_speed > dpmsc_pkg::SPEED_THRESHOLD) begin
                  prop_gain_in  = dpmsc_pkg::PGAIN_FAST;
                  integ_gain_in = dpmsc_pkg::IGAIN_OFF;
               end else begin
                  prop_gain_in  = dpmsc_pkg::PGAIN_BASE;
                  integ_gain_in = dpmsc_pkg::IGAIN_SLOW;
                  preset        = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_mode_ff  <= dpmsc_pkg::MODE_SEARCH;
         prop_gain_ff  <= dpmsc_pkg::PGAIN_RESET;
         integ_gain_ff <= dpmsc_pkg::IGAIN_ONE;
      end else if (accept) begin
         last_mode_ff  <= mode;
         prop_gain_ff  <= prop_gain_in;
         integ_gain_ff <= integ_gain_in;
      end
   end

   assign gains.prop_gain  = prop_gain_in;
   assign gains.integ_gain = integ_gain_in;
   assign gains.preset     = preset;

endmodule

// File: src/dpmsc_lane.sv
// one wheel lane: integrator, gain products, saturation and duty split
`timescale 1ns / 1ps

module dpmsc_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  dpmsc_pkg::pipe_ctrl_type            ctrl,
   input  dpmsc_pkg::gains_type                gains,
   input  logic [dpmsc_pkg::TARGET_W-1:0]      target,
   input  logic signed [dpmsc_pkg::MEAS_W-1:0] measured,
   input  logic [dpmsc_pkg::LIMIT_W-1:0]       forward_limit,
   input  logic [dpmsc_pkg::LIMIT_W-1:0]       reverse_limit,
   output logic [dpmsc_pkg::DUTY_W-1:0]        forward_duty,
   output logic [dpmsc_pkg::DUTY_W-1:0]        reverse_duty
);

   logic signed [dpmsc_pkg::INTEG_W-1:0] integral_ff;
   logic signed [dpmsc_pkg::INTEG_W-1:0] integ_base;
   logic signed [dpmsc_pkg::ERR_W-1:0]   err;
   logic signed [dpmsc_pkg::SUM_W-1:0]   sum;
   logic signed [dpmsc_pkg::INTEG_W-1:0] integral_in;

   logic signed [dpmsc_pkg::ERR_W-1:0]   err_ff;
   logic signed [dpmsc_pkg::INTEG_W-1:0] integ_s1_ff;
   logic [dpmsc_pkg::PGAIN_W-1:0]        prop_gain_ff;
   logic [dpmsc_pkg::IGAIN_W-1:0]        integ_gain_ff;

   logic signed [dpmsc_pkg::DRIVE_W-1:0] prop_full;
   logic signed [dpmsc_pkg::SUM_W-1:0]   integ_full;
   logic signed [dpmsc_pkg::PPROD_W-1:0] prop_ff;
   logic signed [dpmsc_pkg::IPROD_W-1:0] integ_prod_ff;

   logic signed [dpmsc_pkg::DRIVE_W-1:0] drive;
   logic signed [dpmsc_pkg::DRIVE_W-1:0] fwd_lim;
   logic signed [dpmsc_pkg::DRIVE_W-1:0] rev_lim;
   logic signed [dpmsc_pkg::DRIVE_W-1:0] sat;
   logic signed [dpmsc_pkg::DRIVE_W-1:0] sat_neg;
   logic [dpmsc_pkg::DUTY_W-1:0]         forward_duty_ff;
   logic [dpmsc_pkg::DUTY_W-1:0]         reverse_duty_ff;
   logic [dpmsc_pkg::DUTY_W-1:0]         forward_duty_in;
   logic [dpmsc_pkg::DUTY_W-1:0]         reverse_duty_in;

   // error and clamped integrator
   always_comb begin
      integ_base = gains.preset ? dpmsc_pkg::INTEG_PRESET : integral_ff;
      err = $signed({2'b00, target}) - $signed({measured[dpmsc_pkg::MEAS_W-1], measured});
      sum = $signed({{3{integ_base[dpmsc_pkg::INTEG_W-1]}}, integ_base})
            + $signed({err[dpmsc_pkg::ERR_W-1], err});
      if (sum >= dpmsc_pkg::INTEG_HIGH) begin
         integral_in = dpmsc_pkg::INTEG_HIGH[dpmsc_pkg::INTEG_W-1:0];
      end else if (sum <= dpmsc_pkg::INTEG_LOW) begin
         integral_in = dpmsc_pkg::INTEG_LOW[dpmsc_pkg::INTEG_W-1:0];
      end else begin
         integral_in = sum[dpmsc_pkg::INTEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= dpmsc_pkg::INTEG_PRESET;
      end else if (ctrl.load_s1) begin
         integral_ff <= integral_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s1) begin
         err_ff        <= err;
         integ_s1_ff   <= integral_in;
         prop_gain_ff  <= gains.prop_gain;
         integ_gain_ff <= gains.integ_gain;
      end
   end

   // gain products
   always_comb begin
      prop_full  = $signed({{14{1'b0}}, prop_gain_ff})
                   * $signed({{13{err_ff[dpmsc_pkg::ERR_W-1]}}, err_ff});
      integ_full = $signed({{12{1'b0}}, integ_gain_ff})
                   * $signed({{3{integ_s1_ff[dpmsc_pkg::INTEG_W-1]}}, integ_s1_ff});
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s2) begin
         prop_ff       <= prop_full[dpmsc_pkg::PPROD_W-1:0];
         integ_prod_ff <= integ_full[dpmsc_pkg::IPROD_W-1:0];
      end
   end

   // saturate and split to h-bridge duties
   always_comb begin
      drive = $signed({prop_ff[dpmsc_pkg::PPROD_W-1], prop_ff})
              + $signed({{13{integ_prod_ff[dpmsc_pkg::IPROD_W-1]}}, integ_prod_ff});
      fwd_lim = $signed({10'd0, forward_limit});
      rev_lim = -$signed({10'd0, reverse_limit});
      sat = drive;
      if (sat >= fwd_lim) begin
         sat = fwd_lim;
      end
      if (sat < rev_lim) begin
         sat = rev_lim;
      end
      sat_neg = -sat;
      if (sat > 0) begin
         forward_duty_in = sat[dpmsc_pkg::DUTY_W-1:0];
         reverse_duty_in = '0;
      end else begin
         forward_duty_in = '0;
         reverse_duty_in = sat_neg[dpmsc_pkg::DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s3) begin
         forward_duty_ff <= forward_duty_in;
         reverse_duty_ff <= reverse_duty_in;
      end
   end

   assign forward_duty = forward_duty_ff;
   assign reverse_duty = reverse_duty_ff;

endmodule

// File: src/dual_pi_motor_speed_control_top.sv
// top level of the dual wheel pi speed controller
`timescale 1ns / 1ps

// Dual wheel PI speed controller. One transaction on req_bus is one control
// tick; it yields one transaction on rsp_bus with forward and reverse duties
// for both wheels. Two wheel lanes run side by side behind a shared gain
// scheduler and a three stage pipeline (integrator, gain multiply, saturate
// and split); each tick passes through the integrator, product and duty
// registers in turn. A new tick is taken every cycle unless rsp_bus stalls;
// the integrator update of the first stage sets that rate. The result stage
// doubles as the output register; each stage advances when the next is free.
// csr_bus writes forward_limit (index 0) and reverse_limit (index 1) and is
// always ready; write it only while no tick is in flight.

module dual_pi_motor_speed_control_top (
   input  logic               clock,
   input  logic               reset,
   dpmsc_req_if.sink          req_bus,
   dpmsc_rsp_if.source        rsp_bus,
   dpmsc_csr_if.sink          csr_bus
);

   logic                               valid_s1_ff;
   logic                               valid_s2_ff;
   logic                               valid_s3_ff;
   logic                               adv_s1;
   logic                               adv_s2;
   logic                               adv_s3;
   logic                               accept;
   logic [dpmsc_pkg::LIMIT_W-1:0]      forward_limit_ff;
   logic [dpmsc_pkg::LIMIT_W-1:0]      reverse_limit_ff;
   dpmsc_pkg::pipe_ctrl_type           ctrl;
   dpmsc_pkg::gains_type               gains;

   assign adv_s3 = !valid_s3_ff || rsp_bus.ready;
   assign adv_s2 = !valid_s2_ff || adv_s3;
   assign adv_s1 = !valid_s1_ff || adv_s2;
   assign accept = req_bus.valid && adv_s1;

   assign req_bus.ready = adv_s1;
   assign ctrl.load_s1  = accept;
   assign ctrl.load_s2  = valid_s1_ff && adv_s2;
   assign ctrl.load_s3  = valid_s2_ff && adv_s3;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
         valid_s3_ff <= 1'b0;
      end else begin
         if (adv_s1) begin
            valid_s1_ff <= req_bus.valid;
         end
         if (adv_s2) begin
            valid_s2_ff <= valid_s1_ff;
         end
         if (adv_s3) begin
            valid_s3_ff <= valid_s2_ff;
         end
      end
   end

   // limit registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         forward_limit_ff <= dpmsc_pkg::LIMIT_RESET;
         reverse_limit_ff <= dpmsc_pkg::LIMIT_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            dpmsc_pkg::REG_FORWARD_LIMIT: forward_limit_ff <= csr_bus.data;
            dpmsc_pkg::REG_REVERSE_LIMIT: reverse_limit_ff <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   dpmsc_sched u_sched (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .mode          (req_bus.mode),
      .speed_phase   (req_bus.speed_phase),
      .average_speed (req_bus.average_speed),
      .gains         (gains)
   );

   dpmsc_lane u_lane_left (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .gains         (gains),
      .target        (req_bus.left_target),
      .measured      (req_bus.left_measured),
      .forward_limit (forward_limit_ff),
      .reverse_limit (reverse_limit_ff),
      .forward_duty  (rsp_bus.left_forward_duty),
      .reverse_duty  (rsp_bus.left_reverse_duty)
   );

   dpmsc_lane u_lane_right (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .gains         (gains),
      .target        (req_bus.right_target),
      .measured      (req_bus.right_measured),
      .forward_limit (forward_limit_ff),
      .reverse_limit (reverse_limit_ff),
      .forward_duty  (rsp_bus.right_forward_duty),
      .reverse_duty  (rsp_bus.right_reverse_duty)
   );

   assign rsp_bus.valid = valid_s3_ff;

endmodule
